// ===== rtl/gly_pkg.sv =====
// Shared types, constants and the division step for the Golay (24,12) block.
package gly_pkg;

    localparam int DataW   = 12;
    localparam int CheckW  = 11;
    localparam int ByteW   = 8;
    localparam int WordW   = DataW + CheckW;
    localparam int NumSteps = 12;

    // generator polynomial, zero-extended to the working width
    localparam logic [WordW-1:0] GenPoly = WordW'(12'hAE3);

    localparam logic ActEncode = 1'b0;
    localparam logic ActCheck  = 1'b1;

    // one codeword lane in flight: remainder register and the data it came from
    typedef struct packed {
        logic [WordW-1:0] rem;
        logic [DataW-1:0] data;
    } lane_t;

    // everything one word carries down the chain
    typedef struct packed {
        logic  action;
        lane_t a;
        lane_t b;
    } word_t;

    // one step of the division: conditional XOR with the generator, shift right
    function automatic logic [WordW-1:0] div_step(input logic [WordW-1:0] w);
        logic [WordW-1:0] t;
        t = w[0] ? (w ^ GenPoly) : w;
        return t >> 1;
    endfunction

endpackage

// ===== rtl/gly_cell.sv =====
// One division cell of the chain: holds one word and applies one step to both lanes.
module gly_cell
    import gly_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t in_word,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t out_word
);

    logic  valid_reg, valid_next;
    word_t word_reg, word_next;

    // cell takes a new word when empty or when its word moves on
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (in_ready) begin
            valid_next = in_valid;
            word_next.action = in_word.action;
            word_next.a.data = in_word.a.data;
            word_next.b.data = in_word.b.data;
            word_next.a.rem  = div_step(in_word.a.rem);
            word_next.b.rem  = div_step(in_word.b.rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/gly_out.sv =====
// Output register: splits a finished word into code or syndrome fields.
module gly_out
    import gly_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  word_t             in_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DataW-1:0]  m_code_data_a,
    output logic [CheckW-1:0] m_code_check_a,
    output logic              m_code_parity_a,
    output logic [DataW-1:0]  m_code_data_b,
    output logic [CheckW-1:0] m_code_check_b,
    output logic              m_code_parity_b,
    output logic [CheckW-1:0] m_syndrome_a,
    output logic [CheckW-1:0] m_syndrome_b
);

    logic              valid_reg, valid_next;
    logic [DataW-1:0]  data_a_reg, data_a_next, data_b_reg, data_b_next;
    logic [CheckW-1:0] check_a_reg, check_a_next, check_b_reg, check_b_next;
    logic              par_a_reg, par_a_next, par_b_reg, par_b_next;
    logic [CheckW-1:0] syn_a_reg, syn_a_next, syn_b_reg, syn_b_next;
    logic [CheckW-1:0] rem_a, rem_b;

    assign in_ready = !valid_reg || m_ready;
    assign rem_a = in_word.a.rem[CheckW-1:0];
    assign rem_b = in_word.b.rem[CheckW-1:0];

    // route the remainder to check bits or syndrome by action
    always_comb begin
        valid_next   = valid_reg;
        data_a_next  = data_a_reg;
        data_b_next  = data_b_reg;
        check_a_next = check_a_reg;
        check_b_next = check_b_reg;
        par_a_next   = par_a_reg;
        par_b_next   = par_b_reg;
        syn_a_next   = syn_a_reg;
        syn_b_next   = syn_b_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_word.action == ActEncode) begin
                data_a_next  = in_word.a.data;
                data_b_next  = in_word.b.data;
                check_a_next = rem_a;
                check_b_next = rem_b;
                par_a_next   = ^{in_word.a.data, rem_a};
                par_b_next   = ^{in_word.b.data, rem_b};
                syn_a_next   = '0;
                syn_b_next   = '0;
            end else begin
                data_a_next  = '0;
                data_b_next  = '0;
                check_a_next = '0;
                check_b_next = '0;
                par_a_next   = 1'b0;
                par_b_next   = 1'b0;
                syn_a_next   = rem_a;
                syn_b_next   = rem_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_a_reg  <= data_a_next;
        data_b_reg  <= data_b_next;
        check_a_reg <= check_a_next;
        check_b_reg <= check_b_next;
        par_a_reg   <= par_a_next;
        par_b_reg   <= par_b_next;
        syn_a_reg   <= syn_a_next;
        syn_b_reg   <= syn_b_next;
    end

    assign m_valid         = valid_reg;
    assign m_code_data_a   = data_a_reg;
    assign m_code_check_a  = check_a_reg;
    assign m_code_parity_a = par_a_reg;
    assign m_code_data_b   = data_b_reg;
    assign m_code_check_b  = check_b_reg;
    assign m_code_parity_b = par_b_reg;
    assign m_syndrome_a    = syn_a_reg;
    assign m_syndrome_b    = syn_b_reg;

endmodule

// ===== rtl/golay_24_12_encode_and_syndrome_top.sv =====
// Top level of the extended Golay (24,12) encoder and syndrome block.
// Each input word yields one result word. Action 0 packs three bytes into two 12-bit data
// words and returns their 11 check bits and even parity; action 1 returns the syndromes of
// two received data/check pairs (zero when consistent). No error correction is done. The
// block takes one word per cycle while s_ready is high; m_valid rises once the word has
// passed a chain of twelve division cells (one polynomial step each, the first one registering
// the word at the accepting edge) and then the output register. Each cell has its own valid
// bit, so a stall at m_ready fills the chain before s_ready drops.
module golay_24_12_encode_and_syndrome_top
    import gly_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [ByteW-1:0]  s_byte_a,
    input  logic [ByteW-1:0]  s_byte_b,
    input  logic [ByteW-1:0]  s_byte_c,
    input  logic [DataW-1:0]  s_recv_data_a,
    input  logic [CheckW-1:0] s_recv_check_a,
    input  logic [DataW-1:0]  s_recv_data_b,
    input  logic [CheckW-1:0] s_recv_check_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DataW-1:0]  m_code_data_a,
    output logic [CheckW-1:0] m_code_check_a,
    output logic              m_code_parity_a,
    output logic [DataW-1:0]  m_code_data_b,
    output logic [CheckW-1:0] m_code_check_b,
    output logic              m_code_parity_b,
    output logic [CheckW-1:0] m_syndrome_a,
    output logic [CheckW-1:0] m_syndrome_b
);

    logic              chain_valid [NumSteps+1];
    logic              chain_ready [NumSteps+1];
    word_t             chain_word  [NumSteps+1];
    logic [DataW-1:0]  pack_a, pack_b;

    // pack bytes into the two data words
    assign pack_a = {s_byte_b[3:0], s_byte_a};
    assign pack_b = {s_byte_c, s_byte_b[7:4]};

    // entry word: data alone for encode, check above data for syndrome
    always_comb begin
        chain_word[0].action = s_action;
        if (s_action == ActEncode) begin
            chain_word[0].a.rem  = {{CheckW{1'b0}}, pack_a};
            chain_word[0].a.data = pack_a;
            chain_word[0].b.rem  = {{CheckW{1'b0}}, pack_b};
            chain_word[0].b.data = pack_b;
        end else begin
            chain_word[0].a.rem  = {s_recv_check_a, s_recv_data_a};
            chain_word[0].a.data = s_recv_data_a;
            chain_word[0].b.rem  = {s_recv_check_b, s_recv_data_b};
            chain_word[0].b.data = s_recv_data_b;
        end
    end

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];

    // division chain
    for (genvar i = 0; i < NumSteps; i++) begin : g_cell
        gly_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    gly_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (chain_valid[NumSteps]),
        .in_ready        (chain_ready[NumSteps]),
        .in_word         (chain_word[NumSteps]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_data_a   (m_code_data_a),
        .m_code_check_a  (m_code_check_a),
        .m_code_parity_a (m_code_parity_a),
        .m_code_data_b   (m_code_data_b),
        .m_code_check_b  (m_code_check_b),
        .m_code_parity_b (m_code_parity_b),
        .m_syndrome_a    (m_syndrome_a),
        .m_syndrome_b    (m_syndrome_b)
    );

endmodule

// ===== rtl/gly_chk.sv =====
// Port-level checker for the Golay block and its bind to the top level.
module gly_chk
    import gly_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DataW-1:0]  m_code_data_a,
    input logic [CheckW-1:0] m_code_check_a,
    input logic              m_code_parity_a,
    input logic [DataW-1:0]  m_code_data_b,
    input logic [CheckW-1:0] m_code_check_b,
    input logic              m_code_parity_b,
    input logic [CheckW-1:0] m_syndrome_a,
    input logic [CheckW-1:0] m_syndrome_b
);

    // nothing comes out right after reset, and the empty chain takes input
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("m_valid set or s_ready low after reset");

    // a stalled result word holds (checked on m_valid, m_syndrome_a and m_code_data_a)
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_syndrome_a) && $stable(m_code_data_a))
        else $error("stalled result word changed");

    // every codeword leaves with even overall parity
    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (^{m_code_data_a, m_code_check_a, m_code_parity_a}) == 1'b0 &&
                    (^{m_code_data_b, m_code_check_b, m_code_parity_b}) == 1'b0)
        else $error("codeword parity odd");

    // an encode result carries no syndrome
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_code_data_a != '0 || m_code_check_b != '0) |->
            m_syndrome_a == '0 && m_syndrome_b == '0)
        else $error("code and syndrome fields both set");

endmodule

bind golay_24_12_encode_and_syndrome_top gly_chk u_gly_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_code_data_a   (m_code_data_a),
    .m_code_check_a  (m_code_check_a),
    .m_code_parity_a (m_code_parity_a),
    .m_code_data_b   (m_code_data_b),
    .m_code_check_b  (m_code_check_b),
    .m_code_parity_b (m_code_parity_b),
    .m_syndrome_a    (m_syndrome_a),
    .m_syndrome_b    (m_syndrome_b)
);
